// File: rtl/priority_round_robin_scheduler_defines.svh
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_defines
// Assertion macros shared by the scheduler RTL. Both sample on aclk and are
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PRRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prrs assertion failed");

// consequent must hold in the next cycle after the antecedent
`define PRRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prrs assertion failed");

`endif

// File: rtl/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg
// Widths, command codes and shared types of the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

    // field widths of the request and result channels
    localparam int THREAD_ID_W = 4;
    localparam int PRIO_W      = 3;
    localparam int CMD_W       = 2;

    // every thread id and priority code is a legal one
    localparam int NUM_THREADS = 1 << THREAD_ID_W;
    localparam int NUM_LEVELS  = 1 << PRIO_W;

    typedef logic [THREAD_ID_W-1:0] thread_id_t;
    typedef logic [PRIO_W-1:0]      level_t;
    typedef logic [NUM_THREADS-1:0] thread_mask_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACTIVATE = 2'd0,
        CMD_SUSPEND  = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_SET_PRIO = 2'd3
    } cmd_t;

    // running level and its ring head as seen from one copy of the thread state
    typedef struct packed {
        logic       busy;
        level_t     level;
        thread_id_t head;
    } sel_t;

endpackage

// File: rtl/priority_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Thread scheduler with one round-robin ring per priority level.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel s_*: cmd (activate, suspend, timer tick, set priority),
//   thread_id and new_priority. Each request yields exactly one result on
//   m_*: the running thread after the request, the idle flag, and for a
//   tick the switch flag and the thread that ran before the rotation.
//   m_valid rises once the result register loads: the request register loads at
//   the accepting edge, the result register after it once m_ready allows.
//   Throughput is one request per cycle while m_ready is high; the whole
//   update (ring order in a 16x16 age matrix, level encode, head pick) is
//   done in a single pass between the request and result registers.
//   Reset (synchronous, aresetn low) leaves every thread inactive and the
//   block idle; no clearing pass is needed.
//   When the receiver stalls, the result register holds its value and the
//   request register still takes one more request; after that s_ready drops
//   until m_ready returns.
// ----------------------------------------------------------------------------
`include "priority_round_robin_scheduler_defines.svh"

module priority_round_robin_scheduler
    import prrs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_cmd,
    input  logic [THREAD_ID_W-1:0] s_thread_id,
    input  logic [PRIO_W-1:0]      s_new_priority,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [THREAD_ID_W-1:0] m_running_thread,
    output logic                   m_idle_flag,
    output logic                   m_switch_flag,
    output logic [THREAD_ID_W-1:0] m_previous_thread
);

    // request register
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    thread_id_t in_tid_reg;
    level_t     in_prio_reg;

    // thread state
    thread_mask_t active_reg;
    thread_mask_t active_next;
    level_t       level_reg  [NUM_THREADS];
    level_t       level_next [NUM_THREADS];
    thread_mask_t older_reg  [NUM_THREADS];
    thread_mask_t older_next [NUM_THREADS];

    // result register
    logic       out_valid_reg;
    thread_id_t out_running_reg;
    thread_id_t out_running_next;
    logic       out_idle_reg;
    logic       out_idle_next;
    logic       out_switch_reg;
    logic       out_switch_next;
    thread_id_t out_prev_reg;
    thread_id_t out_prev_next;

    logic       advance;
    logic       young_en;
    thread_id_t young_id;
    logic       tick_busy;
    sel_t       pre_sel;
    sel_t       post_sel;
    logic       join_req;
    logic       leave_req;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= cmd_t'(s_cmd);
            in_tid_reg  <= s_thread_id;
            in_prio_reg <= s_new_priority;
        end
    end

    // running level and head before the update
    prrs_select u_pre_select (
        .active (active_reg),
        .level  (level_reg),
        .older  (older_reg),
        .sel    (pre_sel)
    );

    assign tick_busy = (in_cmd_reg == CMD_TICK) && pre_sel.busy;

    // command decode and thread state update
    always_comb begin
        active_next = active_reg;
        level_next  = level_reg;
        older_next  = older_reg;
        young_en    = 1'b0;
        young_id    = in_tid_reg;
        case (in_cmd_reg)
            CMD_ACTIVATE: begin
                if (!active_reg[in_tid_reg]) begin
                    active_next[in_tid_reg] = 1'b1;
                    level_next[in_tid_reg]  = in_prio_reg;
                    young_en                = 1'b1;
                end
            end
            CMD_SUSPEND: begin
                active_next[in_tid_reg] = 1'b0;
            end
            CMD_TICK: begin
                // rotation sends the head to the tail of its ring
                if (pre_sel.busy) begin
                    young_en = 1'b1;
                    young_id = pre_sel.head;
                end
            end
            CMD_SET_PRIO: begin
                active_next[in_tid_reg] = 1'b1;
                level_next[in_tid_reg]  = in_prio_reg;
                young_en                = 1'b1;
            end
            default: begin
            end
        endcase
        // thread joins at the ring tail: every other thread becomes older
        if (young_en) begin
            for (int j = 0; j < NUM_THREADS; j++) begin
                older_next[j][young_id] = 1'b1;
            end
            older_next[young_id] = '0;
        end
    end

    // running level and head after the update
    prrs_select u_post_select (
        .active (active_next),
        .level  (level_next),
        .older  (older_next),
        .sel    (post_sel)
    );

    // result fields
    always_comb begin
        out_running_next = post_sel.busy ? post_sel.head : '0;
        out_idle_next    = !post_sel.busy;
        out_switch_next  = tick_busy && (post_sel.head != pre_sel.head);
        out_prev_next    = tick_busy ? pre_sel.head : '0;
    end

    // thread state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            for (int i = 0; i < NUM_THREADS; i++) begin
                level_reg[i] <= '0;
            end
        end else if (advance) begin
            active_reg <= active_next;
            level_reg  <= level_next;
        end
    end

    // age matrix, only read for active threads
    always_ff @(posedge aclk) begin
        if (advance) begin
            older_reg <= older_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_running_reg <= out_running_next;
            out_idle_reg    <= out_idle_next;
            out_switch_reg  <= out_switch_next;
            out_prev_reg    <= out_prev_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_running_thread  = out_running_reg;
    assign m_idle_flag       = out_idle_reg;
    assign m_switch_flag     = out_switch_reg;
    assign m_previous_thread = out_prev_reg;

    // requests that make a thread active or inactive
    assign join_req  = advance &&
                       ((in_cmd_reg == CMD_ACTIVATE) || (in_cmd_reg == CMD_SET_PRIO));
    assign leave_req = advance && (in_cmd_reg == CMD_SUSPEND);

    // checks
    `PRRS_ASSERT_SAME(a_idle_result, m_valid && m_idle_flag, (m_running_thread == '0) && !m_switch_flag)
    `PRRS_ASSERT_SAME(a_switch_moves, m_valid && m_switch_flag, m_previous_thread != m_running_thread)
    `PRRS_ASSERT_NEXT(a_activate_sets, join_req, active_reg[$past(in_tid_reg)])
    `PRRS_ASSERT_NEXT(a_suspend_clears, leave_req, !active_reg[$past(in_tid_reg)])

endmodule

// File: rtl/prrs_select.sv
// ----------------------------------------------------------------------------
// prrs_select
// Finds the highest nonempty priority level and the thread at the head of
// its ring. Ring order is kept as an age matrix: the head is the oldest
// active thread of the level.
// ----------------------------------------------------------------------------
module prrs_select
    import prrs_pkg::*;
(
    input  thread_mask_t active,
    input  level_t       level [NUM_THREADS],
    input  thread_mask_t older [NUM_THREADS],
    output sel_t         sel
);

    logic [NUM_LEVELS-1:0] nonempty;
    level_t                top;
    thread_mask_t          member;
    thread_mask_t          first;
    thread_id_t            head;

    // occupancy of each level
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            nonempty[l] = 1'b0;
            for (int i = 0; i < NUM_THREADS; i++) begin
                if (active[i] && (level[i] == level_t'(l))) begin
                    nonempty[l] = 1'b1;
                end
            end
        end
    end

    // highest nonempty level
    always_comb begin
        top = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (nonempty[l]) begin
                top = level_t'(l);
            end
        end
    end

    // oldest member of the top level is the ring head
    always_comb begin
        for (int i = 0; i < NUM_THREADS; i++) begin
            member[i] = active[i] && (level[i] == top);
        end
        for (int i = 0; i < NUM_THREADS; i++) begin
            first[i] = member[i];
            for (int j = 0; j < NUM_THREADS; j++) begin
                if ((j != i) && member[j] && older[j][i]) begin
                    first[i] = 1'b0;
                end
            end
        end
    end

    // one-hot to binary
    always_comb begin
        head = '0;
        for (int i = 0; i < NUM_THREADS; i++) begin
            if (first[i]) begin
                head = head | thread_id_t'(i);
            end
        end
    end

    assign sel = '{busy: |nonempty, level: top, head: head};

endmodule
